>>> sv/b64se_pkg.sv
package b64se_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_OFS = 7'h47;
  localparam logic [6:0] ASCII_DIGIT_OFS = 7'h04;
  localparam logic [6:0] ASCII_PLUS = 7'h2B;
  localparam logic [6:0] ASCII_SLASH = 7'h2F;
  localparam logic [6:0] ASCII_PAD = 7'h3D;

  localparam logic [5:0] IDX_LOWER_START = 6'd26;
  localparam logic [5:0] IDX_DIGIT_START = 6'd52;
  localparam logic [5:0] IDX_PLUS = 6'd62;

  localparam logic [1:0] CHAR_POS_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [23:0] grp_bytes;
    logic [1:0]  last_data;
    logic        fin;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] enc_char(input logic [5:0] idx);
    logic [6:0] i7;
    logic [6:0] c;
    i7 = {1'b0, idx};
    if (idx < IDX_LOWER_START) begin
      c = ASCII_UPPER_A + i7;
    end else if (idx < IDX_DIGIT_START) begin
      c = ASCII_LOWER_OFS + i7;
    end else if (idx < IDX_PLUS) begin
      c = i7 - ASCII_DIGIT_OFS;
    end else if (idx == IDX_PLUS) begin
      c = ASCII_PLUS;
    end else begin
      c = ASCII_SLASH;
    end
    return c;
  endfunction

endpackage

>>> sv/base64_stream_encoder_top.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_item_t: data_byte, final_byte
// out_      output     out_valid / out_ready  out_item_t: out_char, last_char
//
// Each byte is taken while the small group queue has room; bytes that complete a group
// or end a message go into that queue, and the back end sends one character per cycle
// while out_ready is high. Three bytes thus become four characters, so the single
// character port sets the sustained rate. A partial last group still sends four characters.
// Reset is synchronous on rst_n and clears the held count, queue and output stage.
// The input side keeps accepting while the queue has room, even when out_ready is low.
module base64_stream_encoder_top #(
  parameter int QDEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b64se_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64se_pkg::out_item_t out_data
);

  b64se_pkg::q_status_t q_stat;
  b64se_pkg::group_t    push_grp;
  b64se_pkg::group_t    head_grp;
  logic                 push;
  logic                 pop;

  b64se_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  b64se_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_grp  (head_grp),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/b64se_front.sv
module b64se_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64se_pkg::in_item_t in_data,
  input  b64se_pkg::q_status_t q_stat,
  output logic                push,
  output b64se_pkg::group_t   push_grp
);

  logic [15:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic [1:0]  cnt;
  logic        accept;
  logic        store;

  assign in_ready = !q_stat.full;
  assign accept = in_valid && in_ready;
  assign cnt = (held_count_r == 2'd3) ? 2'd2 : held_count_r;
  assign store = (cnt < 2'd2) && !in_data.final_byte;
  assign push = accept && !store;

  always_comb begin
    push_grp.fin = in_data.final_byte;
    case (cnt)
      2'd0: begin
        push_grp.grp_bytes = {in_data.data_byte, 16'h0000};
        push_grp.last_data = 2'd1;
      end
      2'd1: begin
        push_grp.grp_bytes = {held_bytes_r[15:8], in_data.data_byte, 8'h00};
        push_grp.last_data = 2'd2;
      end
      default: begin
        push_grp.grp_bytes = {held_bytes_r, in_data.data_byte};
        push_grp.last_data = 2'd3;
      end
    endcase
  end

  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_count_nxt = held_count_r;
    if (accept) begin
      if (store) begin
        if (cnt == 2'd0) begin
          held_bytes_nxt = {in_data.data_byte, 8'h00};
        end else begin
          held_bytes_nxt = {held_bytes_r[15:8], in_data.data_byte};
        end
        held_count_nxt = cnt + 2'd1;
      end else begin
        held_bytes_nxt = 16'h0000;
        held_count_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= 16'h0000;
      held_count_r <= 2'd0;
    end else begin
      held_bytes_r <= held_bytes_nxt;
      held_count_r <= held_count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r != 2'd3)
    else $error("Held byte count reached three.");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.final_byte |=> held_count_r == 2'd0)
    else $error("Pending bytes survived a final byte.");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && store |=> held_count_r == $past(cnt) + 2'd1)
    else $error("Held count did not advance on a stored byte.");

endmodule

>>> sv/b64se_queue.sv
module b64se_queue #(
  parameter int DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64se_pkg::group_t    push_grp,
  input  logic                 pop,
  output b64se_pkg::group_t    head_grp,
  output b64se_pkg::q_status_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64se_pkg::group_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_grp = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("Group written into a full queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("Group taken from an empty queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Queue occupancy exceeds its depth.");

endmodule

>>> sv/b64se_back.sv
module b64se_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64se_pkg::q_status_t q_stat,
  input  b64se_pkg::group_t    head_grp,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64se_pkg::out_item_t out_data
);

  b64se_pkg::group_t   grp_r;
  logic                busy_r;
  logic [1:0]          pos_r;
  logic                out_valid_r;
  b64se_pkg::out_item_t out_r;
  logic                advance;
  logic                grp_done;
  logic [5:0]          idx;
  b64se_pkg::out_item_t char_nxt;

  assign advance = busy_r && (!out_valid_r || out_ready);
  assign grp_done = advance && (pos_r == b64se_pkg::CHAR_POS_LAST);
  assign pop = !q_stat.empty && (!busy_r || grp_done);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    case (pos_r)
      2'd0: idx = grp_r.grp_bytes[23:18];
      2'd1: idx = grp_r.grp_bytes[17:12];
      2'd2: idx = grp_r.grp_bytes[11:6];
      default: idx = grp_r.grp_bytes[5:0];
    endcase
    char_nxt.out_char = (pos_r > grp_r.last_data) ? b64se_pkg::ASCII_PAD
                                                  : b64se_pkg::enc_char(idx);
    char_nxt.last_char = grp_r.fin && (pos_r == b64se_pkg::CHAR_POS_LAST);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= head_grp;
    end
    if (advance) begin
      out_r <= char_nxt;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (grp_done) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        pos_r <= pos_r + 2'd1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pos_r == 2'd0)
    else $error("Character position not at zero while idle.");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!busy_r || pos_r == b64se_pkg::CHAR_POS_LAST))
    else $error("New group taken before the current one finished.");

  assert property (@(posedge clk) disable iff (!rst_n)
    advance && pos_r != b64se_pkg::CHAR_POS_LAST |=> busy_r)
    else $error("Group dropped before its fourth character.");

  assert property (@(posedge clk) disable iff (!rst_n)
    advance && char_nxt.last_char && grp_r.last_data != 2'd3
      |-> char_nxt.out_char == b64se_pkg::ASCII_PAD)
    else $error("Final character of a partial group is not padding.");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

class b64_char_tracker;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_num;
  b64se_pkg::out_item_t pending_chars[$];
  string      alphabet_str;
  int unsigned mismatches;
  int unsigned chars_seen;
  int unsigned bytes_taken;
  int unsigned messages_done;

  function new();
    alphabet_str = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    held_first = '0;
    held_second = '0;
    held_num = '0;
    mismatches = 0;
    chars_seen = 0;
    bytes_taken = 0;
    messages_done = 0;
  endfunction

  // Bytes are held until a group of three is complete or the message ends.
  function void absorb_byte(b64se_pkg::in_item_t it);
    logic [23:0] grp;
    logic [5:0]  idx;
    int          data_chars;
    int          k;
    b64se_pkg::out_item_t c;
    bytes_taken++;
    if (held_num < 2 && !it.final_byte) begin
      if (held_num == 0) begin
        held_first = it.data_byte;
      end else begin
        held_second = it.data_byte;
      end
      held_num++;
      return;
    end
    case (held_num)
      2'd0: begin
        grp = {it.data_byte, 16'h0000};
        data_chars = 2;
      end
      2'd1: begin
        grp = {held_first, it.data_byte, 8'h00};
        data_chars = 3;
      end
      default: begin
        grp = {held_first, held_second, it.data_byte};
        data_chars = 4;
      end
    endcase
    for (k = 0; k < 4; k++) begin
      idx = grp[23 - 6 * k -: 6];
      c.out_char = (k < data_chars) ? 7'(alphabet_str[idx]) : b64se_pkg::ASCII_PAD;
      c.last_char = it.final_byte && (k == 3);
      pending_chars.push_back(c);
    end
    if (it.final_byte) begin
      messages_done++;
    end
    held_first = '0;
    held_second = '0;
    held_num = '0;
  endfunction

  function void match_char(b64se_pkg::out_item_t got);
    b64se_pkg::out_item_t want;
    chars_seen++;
    if (pending_chars.size() == 0) begin
      $error("unexpected character 0x%02h (last_char %0b) with nothing pending",
             got.out_char, got.last_char);
      mismatches++;
      return;
    end
    want = pending_chars.pop_front();
    if (got.out_char !== want.out_char) begin
      $error("out_char: expected 0x%02h, actual 0x%02h", want.out_char, got.out_char);
      mismatches++;
    end
    if (got.last_char !== want.last_char) begin
      $error("last_char: expected %0b, actual %0b", want.last_char, got.last_char);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int ITEM_TARGET = 310;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  b64se_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  b64se_pkg::out_item_t out_data;

  b64_char_tracker tracker;
  bit idling_on;
  bit hold_req;
  bit hold_done;
  int items_sent;
  int idle_cycles;

  base64_stream_encoder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tracker.absorb_byte(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      tracker.match_char(out_data);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_done = 1'b1;
      end else begin
        out_ready <= idling_on ? ($urandom_range(99) >= 17) : 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value, input logic is_final);
    b64se_pkg::in_item_t it;
    it.data_byte = value;
    it.final_byte = is_final;
    while (idling_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Bytes are packed first-byte-most-significant in the low len bytes of msg.
  task automatic send_message(input int len, input logic [47:0] msg);
    int i;
    for (i = 0; i < len; i++) begin
      send_byte(msg[8 * (len - 1 - i) +: 8], i == len - 1);
    end
  endtask

  task automatic send_random_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  initial begin
    int len;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idling_on = 1'b1;
    hold_req = 1'b0;
    hold_done = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_message(1, 48'h00);
    send_message(1, 48'hFF);
    send_message(2, 48'hFFFF);
    send_message(3, 48'h000000);
    send_message(3, 48'hFFFFFF);
    send_message(3, 48'hFBEFBE);
    send_message(4, 48'h80017FFE);
    send_message(5, 48'h123456789A);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 60 && !hold_done && !hold_req) begin
        hold_req = 1'b1;
      end
      idling_on = !(items_sent >= 140 && items_sent < 210);
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(7, 1);
      send_random_message(len);
    end
    in_valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d messages from %0d bytes; %0d characters compared.",
             tracker.messages_done, tracker.bytes_taken, tracker.chars_seen);
    $display("Random idling on both sides, one %0d-cycle receiver stall; %0d mismatches.",
             HOLD_CYCLES, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/b64se_pkg.sv
sv/b64se_front.sv
sv/b64se_queue.sv
sv/b64se_back.sv
sv/base64_stream_encoder_top.sv
sim/tb_top.sv
